FILE: sv/length_prefixed_packet_receiver_macros.svh
// Assertion macros shared by the length-prefixed packet receiver RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef LENGTH_PREFIXED_PACKET_RECEIVER_MACROS_SVH
`define LENGTH_PREFIXED_PACKET_RECEIVER_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define LPPR_ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: property does not hold");
// Consequent that must hold in the cycle after the antecedent.
`define LPPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle consequence missing");
`else
`define LPPR_ASSERT_HOLDS(label, clk, rst, prop)
`define LPPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/lppr_pkg.sv
// Types and constants for the length-prefixed packet receiver.
// No dependencies; used by all modules and the testbench.
package lppr_pkg;

   // Event codes carried in event_res.
   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_START   = 3'd1,
      EV_DATA    = 3'd2,
      EV_DONE    = 3'd3,
      EV_CONNECT = 3'd4,
      EV_TIMEOUT = 3'd5,
      EV_REJECT  = 3'd6
   } event_type;

   // Item kind codes for func.
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // Register indexes of the configuration port.
   localparam logic CSR_TIMEOUT_MS   = 1'b0;
   localparam logic CSR_CONNECT_CODE = 1'b1;

   // Register reset values.
   localparam logic [15:0] TIMEOUT_MS_RESET   = 16'd100;
   localparam logic [7:0]  CONNECT_CODE_RESET = 8'h0A;

   // Saturation value of the elapsed counter.
   localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

   // Connect requests are exactly two payload bytes long.
   localparam logic [7:0] CONNECT_LENGTH = 8'd2;

   // Configuration register contents.
   typedef struct packed {
      logic [15:0] timeout_ms;
      logic [7:0]  connect_code;
   } cfg_type;

   // One result beat.
   typedef struct packed {
      event_type  event_res;
      logic [7:0] data_byte;
      logic [6:0] byte_index;
      logic [6:0] packet_length;
   } rsp_type;

   // Receiver status, lengths zero-extended to the widest byte length.
   typedef struct packed {
      logic       in_progress;
      logic [7:0] received_count;
      logic [7:0] expected_length;
   } status_type;

endpackage

FILE: sv/lppr_channels.sv
// Valid/ready channel interfaces for request and response beats.
// No dependencies.
interface lppr_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface lppr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic [7:0] data_byte;
   logic [6:0] byte_index;
   logic [6:0] packet_length;

   modport source (output valid, output event_res, output data_byte,
                   output byte_index, output packet_length, input ready);
   modport sink   (input valid, input event_res, input data_byte,
                   input byte_index, input packet_length, output ready);
endinterface

FILE: sv/lppr_engine.sv
// Receiver state and per-beat update logic; computes one result per accepted beat.
// Depends on lppr_pkg.
module lppr_engine
   import lppr_pkg::*;
#(
   parameter int MAX_DATA = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       func,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output rsp_type    result,
   output status_type status
);

   localparam int LEN_W = $clog2(MAX_DATA + 1);
   localparam logic [8:0] MAX_LEN = 9'(MAX_DATA);

   logic             in_progress_ff, in_progress_in;
   logic [LEN_W-1:0] expected_ff, expected_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [7:0]       first_payload_ff, first_payload_in;
   logic [15:0]      elapsed_ff, elapsed_in;

   logic [15:0]      elapsed_inc;
   logic [LEN_W-1:0] count_inc;
   logic [7:0]       count_inc_w;
   logic [7:0]       expected_w;
   logic [7:0]       count_w;
   logic             length_ok;

   // Lengths are reported masked to the seven-bit result fields.
   function automatic logic [6:0] to_field(input logic [7:0] value);
      return value[6:0];
   endfunction

   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 16'd1;
   assign count_inc   = count_ff + LEN_W'(1);
   assign count_inc_w = 8'(count_inc);
   assign count_w     = 8'(count_ff);
   assign expected_w  = 8'(expected_ff);
   assign length_ok   = (rx_byte != 8'd0) && ({1'b0, rx_byte} <= MAX_LEN);

   // Next state and result for the beat on the input.
   always_comb begin
      in_progress_in   = in_progress_ff;
      expected_in      = expected_ff;
      count_in         = count_ff;
      first_payload_in = first_payload_ff;
      elapsed_in       = elapsed_ff;
      result           = '{event_res: EV_NONE, data_byte: 8'd0,
                           byte_index: 7'd0, packet_length: 7'd0};

      if (func == FUNC_TICK) begin
         elapsed_in = elapsed_inc;
         if (in_progress_ff && (elapsed_inc > cfg.timeout_ms)) begin
            in_progress_in       = 1'b0;
            result.event_res     = EV_TIMEOUT;
            result.byte_index    = to_field(count_w);
            result.packet_length = to_field(expected_w);
         end
      end else if (!in_progress_ff) begin
         if (length_ok) begin
            in_progress_in       = 1'b1;
            expected_in          = LEN_W'(rx_byte);
            count_in             = '0;
            elapsed_in           = 16'd0;
            result.event_res     = EV_START;
            result.packet_length = to_field(rx_byte);
         end else begin
            result.event_res = EV_REJECT;
            result.data_byte = rx_byte;
         end
      end else begin
         count_in = count_inc;
         if (count_inc_w == 8'd1) begin
            first_payload_in = rx_byte;
         end
         result.data_byte     = rx_byte;
         result.byte_index    = to_field(count_inc_w);
         result.packet_length = to_field(expected_w);
         if (count_inc == expected_ff) begin
            in_progress_in = 1'b0;
            // A two-byte packet opened by the connect code is a connect request.
            if ((count_inc_w == CONNECT_LENGTH) && (first_payload_ff == cfg.connect_code)) begin
               result.event_res = EV_CONNECT;
            end else begin
               result.event_res = EV_DONE;
            end
         end else begin
            result.event_res = EV_DATA;
         end
      end
   end

   // State registers, updated on each accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_progress_ff   <= 1'b0;
         expected_ff      <= '0;
         count_ff         <= '0;
         first_payload_ff <= 8'd0;
         elapsed_ff       <= 16'd0;
      end else if (accept) begin
         in_progress_ff   <= in_progress_in;
         expected_ff      <= expected_in;
         count_ff         <= count_in;
         first_payload_ff <= first_payload_in;
         elapsed_ff       <= elapsed_in;
      end
   end

   assign status = '{in_progress: in_progress_ff, received_count: count_w,
                     expected_length: expected_w};

endmodule

FILE: sv/lppr_out_reg.sv
// Output register stage: holds one result beat until the consumer takes it.
// Depends on lppr_pkg.
module lppr_out_reg
   import lppr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    valid_ff;
   rsp_type data_ff;

   // A new beat may enter when the stage is empty or drains this cycle.
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: sv/length_prefixed_packet_receiver.sv
// Top level of the length-prefixed packet receiver: channels, CSRs, checks.
// Depends on lppr_pkg, the channel interfaces, lppr_engine, lppr_out_reg and the macro header.
`include "length_prefixed_packet_receiver_macros.svh"

// Receives length-prefixed packets from a UART byte stream, one request beat per
// received byte or per one-millisecond tick, and answers every request beat with
// exactly one response beat (start, data, done, connect, timeout, reject or none).
// The receiver state updates as a beat is accepted, and the result lands in a
// one-deep output register that is refilled in the same cycle it drains, so a
// beat can be accepted every cycle while the response side keeps up. The
// response appears in the cycle after its request is accepted. The user must
// write timeout_ms (index 0) and connect_code (index 1) through the CSR port
// only while no beat is in flight; the block itself does not enforce this.
module length_prefixed_packet_receiver
   import lppr_pkg::*;
#(
   parameter int MAX_DATA = 64
) (
   input  logic        clock,
   input  logic        reset,
   lppr_req_if.sink    req_ch,
   lppr_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   cfg_type    cfg_ff;
   rsp_type    engine_rsp;
   rsp_type    out_rsp;
   status_type status;
   logic       req_ready;
   logic       accept;
   logic       rsp_held;
   logic       count_in_range;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms   <= TIMEOUT_MS_RESET;
         cfg_ff.connect_code <= CONNECT_CODE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TIMEOUT_MS:   cfg_ff.timeout_ms   <= csr_wdata;
            CSR_CONNECT_CODE: cfg_ff.connect_code <= csr_wdata[7:0];
            default:          ;
         endcase
      end
   end

   assign accept       = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;

   lppr_engine #(
      .MAX_DATA (MAX_DATA)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .func    (req_ch.func),
      .rx_byte (req_ch.rx_byte),
      .cfg     (cfg_ff),
      .result  (engine_rsp),
      .status  (status)
   );

   lppr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ready),
      .in_data   (engine_rsp),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_rsp)
   );

   assign rsp_ch.event_res     = 3'(out_rsp.event_res);
   assign rsp_ch.data_byte     = out_rsp.data_byte;
   assign rsp_ch.byte_index    = out_rsp.byte_index;
   assign rsp_ch.packet_length = out_rsp.packet_length;

   // Conditions watched by the checks below.
   assign rsp_held       = rsp_ch.valid && !rsp_ch.ready;
   assign count_in_range = !status.in_progress ||
                           (status.received_count < status.expected_length);

   // A held response blocks new requests.
   `LPPR_ASSERT_HOLDS(a_stall_blocks_req, clock, reset, !rsp_held || !req_ch.ready)
   // Every accepted request shows up as a response beat in the next cycle.
   `LPPR_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_ch.valid)
   // While a packet is open, fewer bytes than its length have been counted.
   `LPPR_ASSERT_HOLDS(a_count_below_length, clock, reset, count_in_range)

endmodule

FILE: tb/sv/length_prefixed_packet_receiver_test.sv
`timescale 1ns / 100ps
// Self-checking test of the length-prefixed packet receiver over its request,
// response and CSR ports. Depends on lppr_pkg, the channel interfaces and the RTL.

module length_prefixed_packet_receiver_test;
   import lppr_pkg::*;

   localparam int MAX_LEN        = 64;
   localparam int STALL_LIMIT    = 2000;
   localparam int PHASE_BEATS    = 170;
   localparam int SATURATE_TICKS = 40;

   // Tracks the receiver state and predicts one response beat per request beat.
   class packet_tracker;
      cfg_type     cfg;
      logic        in_progress;
      logic [6:0]  expected_length;
      logic [6:0]  received_count;
      logic [7:0]  first_payload;
      logic [15:0] elapsed_ms;
      rsp_type     predicted_events[$];
      int          mismatches;

      function new();
         cfg.timeout_ms   = TIMEOUT_MS_RESET;
         cfg.connect_code = CONNECT_CODE_RESET;
         in_progress      = 1'b0;
         expected_length  = '0;
         received_count   = '0;
         first_payload    = '0;
         elapsed_ms       = '0;
         mismatches       = 0;
      endfunction

      function void write_register(logic idx, logic [15:0] value);
         if (idx == CSR_TIMEOUT_MS) begin
            cfg.timeout_ms = value;
         end else begin
            cfg.connect_code = value[7:0];
         end
      endfunction

      function int pending();
         return predicted_events.size();
      endfunction

      // Advance the state by one accepted request beat and queue its result.
      function void note_request_beat(logic func, logic [7:0] rx_byte);
         rsp_type r;
         r = '0;
         if (func == FUNC_TICK) begin
            if (elapsed_ms != ELAPSED_MAX) begin
               elapsed_ms = elapsed_ms + 16'd1;
            end
            if (in_progress && elapsed_ms > cfg.timeout_ms) begin
               in_progress     = 1'b0;
               r.event_res     = EV_TIMEOUT;
               r.byte_index    = received_count;
               r.packet_length = expected_length;
            end
         end else if (!in_progress) begin
            // An idle receiver reads the byte as a payload length.
            if (rx_byte >= 1 && rx_byte <= MAX_LEN) begin
               in_progress     = 1'b1;
               expected_length = rx_byte[6:0];
               received_count  = '0;
               elapsed_ms      = '0;
               r.event_res     = EV_START;
               r.packet_length = rx_byte[6:0];
            end else begin
               r.event_res = EV_REJECT;
               r.data_byte = rx_byte;
            end
         end else begin
            received_count = received_count + 7'd1;
            if (received_count == 7'd1) begin
               first_payload = rx_byte;
            end
            r.data_byte     = rx_byte;
            r.byte_index    = received_count;
            r.packet_length = expected_length;
            if (received_count == expected_length) begin
               in_progress = 1'b0;
               if (received_count == CONNECT_LENGTH && first_payload == cfg.connect_code) begin
                  r.event_res = EV_CONNECT;
               end else begin
                  r.event_res = EV_DONE;
               end
            end else begin
               r.event_res = EV_DATA;
            end
         end
         predicted_events.push_back(r);
      endfunction

      // Compare one accepted response beat with the oldest prediction.
      function void check_response_beat(logic [2:0] ev, logic [7:0] data_byte,
                                        logic [6:0] byte_index, logic [6:0] packet_length);
         rsp_type e;
         if (predicted_events.size() == 0) begin
            $display("%0t: unexpected response beat: event %0d data %02h index %0d length %0d",
                     $time, ev, data_byte, byte_index, packet_length);
            mismatches++;
            return;
         end
         e = predicted_events.pop_front();
         if (e.event_res !== ev || e.data_byte !== data_byte ||
             e.byte_index !== byte_index || e.packet_length !== packet_length) begin
            $display("%0t: mismatch: expected event %0d data %02h index %0d length %0d",
                     $time, e.event_res, e.data_byte, e.byte_index, e.packet_length);
            $display("%0t:           actual event %0d data %02h index %0d length %0d",
                     $time, ev, data_byte, byte_index, packet_length);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic        csr_addr;
   logic [15:0] csr_wdata;

   lppr_req_if req_bus();
   lppr_rsp_if rsp_bus();

   packet_tracker tracker = new();

   int send_idle_pct;
   int rsp_idle_pct;
   int tick_pct;
   int holdoff_request;
   int holdoff_left;
   int stall_cycles;
   int phase_beats;

   length_prefixed_packet_receiver #(.MAX_DATA(MAX_LEN)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Response side: random stalls, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      if (holdoff_request > 0) begin
         holdoff_left    = holdoff_request;
         holdoff_request = 0;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_bus.ready = 1'b0;
      end else begin
         rsp_bus.ready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Check every response beat as it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         tracker.check_response_beat(rsp_bus.event_res, rsp_bus.data_byte,
                                     rsp_bus.byte_index, rsp_bus.packet_length);
      end
   end

   // Watchdog: end the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("length_prefixed_packet_receiver_test NOT OK");
            $finish;
         end
      end
   end

   // Offer one request beat, with random idle cycles first. Starts and ends
   // at a falling edge; valid stays high so a following beat needs no toggle.
   task automatic send_item(input logic func, input logic [7:0] rx_byte);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid   = 1'b1;
      req_bus.func    = func;
      req_bus.rx_byte = rx_byte;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_request_beat(func, rx_byte);
      phase_beats++;
      @(negedge clock);
   endtask

   task automatic send_tick();
      send_item(FUNC_TICK, 8'($urandom_range(255)));
   endtask

   // Stop offering beats and wait until every predicted response is out.
   task automatic drain();
      req_bus.valid = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      drain();
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      tracker.write_register(idx, value);
   endtask

   // One stretch of random traffic: mostly whole packets with random content,
   // sometimes a stray byte, a stray tick or a packet cut short.
   task automatic send_random_unit();
      int         r;
      int         len;
      logic [7:0] b;
      r = $urandom_range(99);
      if (r < 6) begin
         send_item(FUNC_BYTE, 8'($urandom_range(255)));
      end else if (r < 12) begin
         send_tick();
      end else begin
         if (r < 17) begin
            len = MAX_LEN;
         end else if (r < 40) begin
            len = 2;
         end else begin
            len = $urandom_range(8, 1);
         end
         send_item(FUNC_BYTE, 8'(len));
         for (int i = 1; i <= len; i++) begin
            while ($urandom_range(99) < tick_pct) send_tick();
            if ($urandom_range(99) < 3) break;
            if (len == 2 && i == 1 && $urandom_range(1)) begin
               b = tracker.cfg.connect_code;
            end else begin
               b = 8'($urandom_range(255));
            end
            send_item(FUNC_BYTE, b);
         end
      end
   endtask

   initial begin
      logic [15:0] timeouts [6];
      logic [7:0]  codes [6];
      logic        held_off;

      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_addr        = CSR_TIMEOUT_MS;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.func    = FUNC_BYTE;
      req_bus.rx_byte = '0;
      rsp_bus.ready   = 1'b0;
      send_idle_pct   = 26;
      rsp_idle_pct    = 53;
      tick_pct        = 10;
      holdoff_request = 0;
      holdoff_left    = 0;
      stall_cycles    = 0;
      phase_beats     = 0;
      held_off        = 1'b0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Directed beats at the reset register values: rejected lengths, an idle
      // tick, one-, two- and three-byte packets, a connect request with ticks.
      send_tick();
      send_item(FUNC_BYTE, 8'h00);
      send_item(FUNC_BYTE, 8'(MAX_LEN + 1));
      send_item(FUNC_BYTE, 8'hFF);
      send_item(FUNC_BYTE, 8'h01);
      send_item(FUNC_BYTE, 8'hFF);
      send_item(FUNC_BYTE, 8'h02);
      send_tick();
      send_item(FUNC_BYTE, CONNECT_CODE_RESET);
      send_tick();
      send_item(FUNC_BYTE, 8'h55);
      send_item(FUNC_BYTE, 8'h02);
      send_item(FUNC_BYTE, 8'h0B);
      send_item(FUNC_BYTE, 8'h00);
      send_item(FUNC_BYTE, 8'h03);
      send_item(FUNC_BYTE, CONNECT_CODE_RESET);
      send_item(FUNC_BYTE, 8'h01);
      send_item(FUNC_BYTE, 8'h80);

      // Timeout of one: the second tick after the length aborts the packet.
      write_csr(CSR_TIMEOUT_MS, 16'd1);
      write_csr(CSR_CONNECT_CODE, 16'h00FF);
      send_item(FUNC_BYTE, 8'h04);
      send_item(FUNC_BYTE, 8'hA5);
      send_tick();
      send_tick();

      // Zero timeout: the first tick in a packet aborts it.
      write_csr(CSR_TIMEOUT_MS, 16'd0);
      send_item(FUNC_BYTE, 8'h01);
      send_tick();

      // Random phases, each with its own register settings and idle pattern.
      timeouts = '{16'hFFFF, 16'd2, 16'd3, 16'd0, 16'd8, 16'd1};
      codes    = '{8'h00, 8'hFF, 8'($urandom_range(255)), CONNECT_CODE_RESET,
                   8'($urandom_range(255)), 8'hAA};
      for (int phase = 0; phase < 6; phase++) begin
         write_csr(CSR_TIMEOUT_MS, timeouts[phase]);
         write_csr(CSR_CONNECT_CODE, {8'h00, codes[phase]});
         if (phase < 2) begin
            send_idle_pct = 26;
            rsp_idle_pct  = 53;
         end else if (phase < 4) begin
            send_idle_pct = 53;
            rsp_idle_pct  = 26;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         phase_beats = 0;
         held_off    = 1'b0;
         while (phase_beats < PHASE_BEATS) begin
            // Hold the response side off so the receiver fills and stalls.
            if ((phase == 2 || phase == 4) && !held_off && phase_beats >= 60) begin
               holdoff_request = 80;
               held_off        = 1'b1;
            end
            send_random_unit();
         end
      end

      // Largest timeout: a packet survives a long run of ticks.
      write_csr(CSR_TIMEOUT_MS, 16'hFFFF);
      send_item(FUNC_BYTE, 8'h03);
      send_item(FUNC_BYTE, 8'h5A);
      for (int i = 0; i < SATURATE_TICKS; i++) begin
         send_tick();
      end
      send_item(FUNC_BYTE, 8'hC3);
      send_item(FUNC_BYTE, 8'h3C);

      req_bus.valid = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("length_prefixed_packet_receiver_test OK");
      end else begin
         $display("length_prefixed_packet_receiver_test NOT OK");
      end
      $finish;
   end

endmodule
